[rtl/spmrng_pkg.sv]
package spmrng_pkg;

	// Minimal-standard generator constants.
	localparam logic [14:0] PM_MULT    = 15'd16807;
	localparam logic [30:0] PM_MOD     = 31'h7FFF_FFFF;
	localparam int unsigned WARM_EXTRA = 8;

	// Table slot estimate: the top bits of the last output times a scaled
	// reciprocal of the slot width, followed by one correction step.
	localparam int unsigned EST_DROP  = 20;
	localparam int unsigned EST_HI_W  = 31 - EST_DROP;
	localparam int unsigned RECIP_SH  = 36;
	localparam int unsigned RECIP_W   = 12;
	localparam int unsigned EST_PRD_W = EST_HI_W + RECIP_W;
	localparam int unsigned EST_SH    = RECIP_SH - EST_DROP;
	localparam int unsigned EST_W     = EST_PRD_W - EST_SH;
	localparam int unsigned CMP_W     = EST_W + 1 + 31;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_W_MUL,
		ST_W_FOLD,
		ST_D_MUL,
		ST_D_FOLD,
		ST_D_SLOT,
		ST_D_READ,
		ST_D_OUT
	} spmrng_state_t;

	typedef struct packed {
		logic seed_load;
		logic mul;
		logic warm_fold;
		logic est;
		logic draw_fold;
		logic slot;
		logic swap;
		logic out_load;
	} spmrng_cmd_t;

endpackage

[rtl/spmrng_ctrl.sv]
module spmrng_ctrl
	import spmrng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	input  logic        last_step,
	output spmrng_cmd_t cmd
);

	spmrng_state_t state_q, state_d;
	logic          init_pending_q;
	logic          out_valid_q;
	logic          accept;
	logic          out_free;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			init_pending_q <= 1'b1;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_W_FOLD && last_step) begin
				init_pending_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (restart || init_pending_q) ? ST_SEED : ST_D_MUL;
				end
			end
			ST_SEED:   state_d = ST_W_MUL;
			ST_W_MUL:  state_d = ST_W_FOLD;
			ST_W_FOLD: state_d = last_step ? ST_D_MUL : ST_W_MUL;
			ST_D_MUL:  state_d = ST_D_FOLD;
			ST_D_FOLD: state_d = ST_D_SLOT;
			ST_D_SLOT: state_d = ST_D_READ;
			ST_D_READ: state_d = ST_D_OUT;
			ST_D_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready      = 1'b1;
			ST_SEED:   cmd.seed_load = 1'b1;
			ST_W_MUL:  cmd.mul       = 1'b1;
			ST_W_FOLD: cmd.warm_fold = 1'b1;
			ST_D_MUL: begin
				cmd.mul = 1'b1;
				cmd.est = 1'b1;
			end
			ST_D_FOLD: cmd.draw_fold = 1'b1;
			ST_D_SLOT: cmd.slot      = 1'b1;
			ST_D_READ: cmd.swap      = 1'b1;
			ST_D_OUT:  cmd.out_load  = out_free;
			default:   cmd           = '0;
		endcase
	end

	assign out_valid = out_valid_q;

	// A pending first warm-up must be taken by the first accepted item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && init_pending_q) |=> (state_q == ST_SEED))
		else $error("pending warm-up skipped");

	// The warm-up always ends with the pending flag cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_W_FOLD && last_step) |=> !init_pending_q)
		else $error("warm-up finished but still pending");

	// A result never overwrites one that the receiver has not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// No item is taken while a draw is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("ready during a draw");

endmodule

[rtl/spmrng_dp.sv]
module spmrng_dp
	import spmrng_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data,
	input  spmrng_cmd_t cmd,
	output logic        last_step,
	output logic [30:0] value
);

	localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
	localparam int unsigned WARM_N  = TABLE_DEPTH + WARM_EXTRA;
	localparam int unsigned CNT_W   = $clog2(WARM_N);
	localparam logic [63:0] SLOT_DIV64 = 64'd1 + (64'd2147483646 / 64'(TABLE_DEPTH));
	localparam logic [30:0] SLOT_DIV   = SLOT_DIV64[30:0];
	localparam logic [63:0] RECIP64    = (64'd1 << RECIP_SH) / SLOT_DIV64;
	localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

	logic [30:0]          seed_q;
	logic [30:0]          x_q;
	logic [45:0]          prod_q;
	logic [30:0]          last_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [EST_W-1:0]     est_q;
	logic [CMP_W-1:0]     cmp_q;
	logic [IDX_W-1:0]     slot_q;
	logic [30:0]          rd_q;
	logic [30:0]          value_q;
	logic [30:0]          tbl_mem [TABLE_DEPTH];

	logic [31:0]          fold_sum;
	logic [30:0]          fold;
	logic [30:0]          seed_fix;
	logic [EST_PRD_W-1:0] est_prd;
	logic [EST_W:0]       slot_corr;
	logic                 warm_fill;
	logic [CNT_W:0]       warm_addr;
	logic                 tbl_we;
	logic [IDX_W-1:0]     tbl_wa;
	logic [30:0]          tbl_wd;

	// x * 16807 mod (2^31 - 1): fold the high part onto the low part once.
	assign fold_sum = 32'(prod_q[30:0]) + 32'(prod_q[45:31]);
	assign fold     = (fold_sum >= 32'(PM_MOD)) ? 31'(fold_sum - 32'(PM_MOD))
	                                            : fold_sum[30:0];

	assign seed_fix  = (seed_q == PM_MOD || seed_q == '0) ? 31'd1 : seed_q;
	assign last_step = (cnt_q == CNT_W'(WARM_N - 1));
	assign warm_fill = (cnt_q >= CNT_W'(WARM_EXTRA));
	assign warm_addr = (CNT_W + 1)'(WARM_N - 1) - {1'b0, cnt_q};
	assign est_prd   = EST_PRD_W'(last_q[30:EST_DROP]) * EST_PRD_W'(RECIP);

	always_comb begin
		slot_corr = {1'b0, est_q};
		if (CMP_W'(last_q) >= cmp_q) begin
			slot_corr = slot_corr + 1'b1;
		end
		if (slot_corr >= (EST_W + 1)'(TABLE_DEPTH)) begin
			slot_corr = (EST_W + 1)'(TABLE_DEPTH - 1);
		end
	end

	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = slot_q;
		tbl_wd = x_q;
		if (cmd.warm_fold && warm_fill) begin
			tbl_we = 1'b1;
			tbl_wa = warm_addr[IDX_W-1:0];
			tbl_wd = fold;
		end else if (cmd.swap) begin
			tbl_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 31'd1;
			x_q    <= 31'd1;
			last_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (cmd.seed_load) begin
				x_q   <= seed_fix;
				cnt_q <= '0;
			end
			if (cmd.warm_fold) begin
				x_q   <= fold;
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					last_q <= fold;
				end
			end
			if (cmd.draw_fold) begin
				x_q <= fold;
			end
			if (cmd.out_load) begin
				last_q <= rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= 46'(x_q) * 46'(PM_MULT);
		end
		if (cmd.est) begin
			est_q <= est_prd[EST_PRD_W-1:EST_SH];
		end
		if (cmd.draw_fold) begin
			cmp_q <= CMP_W'({1'b0, est_q} + 1'b1) * CMP_W'(SLOT_DIV);
		end
		if (cmd.slot) begin
			slot_q <= slot_corr[IDX_W-1:0];
		end
		if (cmd.out_load) begin
			value_q <= rd_q;
		end
	end

	// Shuffle table: read-before-write on the swap, so the old entry leaves.
	always_ff @(posedge clk) begin
		if (cmd.swap) begin
			rd_q <= tbl_mem[slot_q];
		end
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
	end

	assign value = value_q;

	// The generator never leaves 1 .. 2^31-2.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.warm_fold || cmd.draw_fold || cmd.seed_load) |=>
		(x_q != '0 && x_q != PM_MOD))
		else $error("generator left its range");

	// The chosen slot does not overshoot the last output: slot * width <= last output.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slot |=> (CMP_W'(slot_q) * CMP_W'(SLOT_DIV) <= CMP_W'(last_q)))
		else $error("slot estimate too high");

	// The warm-up counter stays inside the warm-up length.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.warm_fold |-> (cnt_q <= CNT_W'(WARM_N - 1)))
		else $error("warm-up counter overran");

endmodule

[rtl/shuffled_park_miller_rng.sv]
// Shuffled minimal-standard random number generator.
//
// Each item accepted on the input channel (in_valid / in_ready) is one
// request and yields exactly one 31-bit item on the output channel
// (out_valid / out_ready): value, in 1 .. 2^31-2. Its uniform fraction is
// value / (2^31-1). An item with restart set reseeds the generator from
// the seed register and warms it up before its draw.
// In an ordinary draw, out_valid and in_ready rise together, and the next
// item can be taken as soon as in_ready is high; no item is taken while a
// draw is in progress. The draw is a fixed sequence: modular multiply
// with the table slot estimate, fold, slot correction, one read-and-replace
// of the shuffle table memory, and the output load.
// A warm-up loads the seed and then runs TABLE_DEPTH + 8 generator steps:
// every generator step is a multiply followed by a modulo fold.
// After reset the first request always warms up, even with restart clear.
// The seed register is written through cfg_wr_en / cfg_wr_data and is
// used at the next warm-up only. A result waits in the output register
// while the receiver stalls. One more item is still taken and computed,
// but its result waits in the last draw step until the register frees,
// and no further item is taken in the meantime.
module shuffled_park_miller_rng
	import spmrng_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] value
);

	spmrng_cmd_t cmd;
	logic        last_step;

	// The sequencer walks through warm-up and draw steps.
	spmrng_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.last_step (last_step),
		.cmd       (cmd)
	);

	// The datapath holds the generator, the shuffle table and the result.
	spmrng_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.last_step   (last_step),
		.value       (value)
	);

endmodule
